### design/dra_pkg.sv
package dra_pkg;

  localparam int unsigned MaxAnswers = 64;
  localparam int unsigned MaxLabels  = 128;

  localparam int unsigned AnsW = $clog2(MaxAnswers + 1);
  localparam int unsigned LblW = $clog2(MaxLabels + 2);

  localparam int unsigned IdW       = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned StatusW   = 4;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned OutDataW  = ((StatusW + AddrW + 7) / 8) * 8;
  localparam int unsigned OutPadW   = OutDataW - StatusW - AddrW;
  localparam int unsigned HdrLast   = 11;
  localparam int unsigned QTailLen  = 4;
  localparam int unsigned RrHdrLast = 9;

  localparam logic [ByteW-1:0] QrMask     = 8'h80;
  localparam logic [ByteW-1:0] OpcodeMask = 8'h78;
  localparam logic [ByteW-1:0] RcodeMask  = 8'h0F;
  localparam logic [ByteW-1:0] PtrMask    = 8'hC0;

  localparam logic [15:0] RrTypeA  = 16'd1;
  localparam logic [15:0] RrClassIn = 16'd1;
  localparam logic [15:0] RrLenA   = 16'd4;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_QNAME  = 3'd1,
    PH_QPTR   = 3'd2,
    PH_QTAIL  = 3'd3,
    PH_ANAME  = 3'd4,
    PH_APTR   = 3'd5,
    PH_RRHDR  = 3'd6,
    PH_RDATA  = 3'd7
  } phase_e;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_SHORT       = 4'd1,
    ST_ID          = 4'd2,
    ST_NOT_RESP    = 4'd3,
    ST_OPCODE      = 4'd4,
    ST_RCODE       = 4'd5,
    ST_NO_ANSWERS  = 4'd6,
    ST_QUESTION    = 4'd7,
    ST_ANSWER_NAME = 4'd8,
    ST_RR_HEADER   = 4'd9,
    ST_RDATA       = 4'd10,
    ST_NO_A        = 4'd11
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } beat_t;

  typedef struct packed {
    status_e          status;
    logic [AddrW-1:0] address;
  } result_t;

  function automatic status_e end_error(input phase_e ph);
    status_e st;
    case (ph)
      PH_HEADER:                   st = ST_SHORT;
      PH_QNAME, PH_QPTR, PH_QTAIL: st = ST_QUESTION;
      PH_ANAME, PH_APTR:           st = ST_ANSWER_NAME;
      PH_RRHDR:                    st = ST_RR_HEADER;
      default:                     st = ST_RDATA;
    endcase
    return st;
  endfunction

endpackage

### design/dns_response_a_record_extractor.sv
// Channel  | Direction | Signals                            | Contents
// s_axis   | in        | tvalid, tready, tdata[7:0], tlast  | message byte, last byte flag
// m_axis   | out       | tvalid, tready, tdata[39:0]        | status, IPv4 address
// cfg      | in        | valid, ready, data[15:0]           | expected transaction id
//
// One message byte is taken per cycle unless a held result stalls the input; the byte path
// is a single pass from the input register through the parser update into the result register.
// The result is loaded into the result register as the last byte leaves the input register.
// Reset clears parse state and the expected id; each result returns parse state to reset.
// A held result stalls s_axis only when a second last byte reaches the input register.
module dns_response_a_record_extractor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [dra_pkg::ByteW-1:0]      s_axis_tdata_i,   // [7:0] data_byte
  input  logic                           s_axis_tlast_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [dra_pkg::OutDataW-1:0]   m_axis_tdata_o,   // [3:0] status, [35:4] address, rest zero
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dra_pkg::IdW-1:0]        cfg_data_i
);
  import dra_pkg::*;

  logic [IdW-1:0] expected_id_q;
  logic           in_valid;
  beat_t          in_beat;
  beat_t          s_beat;
  logic           advance;
  logic           load;
  result_t        result;
  logic           out_valid_q, out_valid_d;
  result_t        out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_id_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      expected_id_q <= cfg_data_i;
    end
  end

  assign s_beat.data = s_axis_tdata_i;
  assign s_beat.last = s_axis_tlast_i;

  assign advance = in_valid && (!in_beat.last || !out_valid_q || m_axis_tready_i);
  assign load    = advance && in_beat.last;

  dra_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_beat_i  (s_beat),
    .advance_i (advance),
    .valid_o   (in_valid),
    .beat_o    (in_beat)
  );

  dra_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .beat_i        (in_beat),
    .expected_id_i (expected_id_q),
    .result_o      (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) out_valid_d = 1'b0;
    if (load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{OutPadW{1'b0}}, out_q.address, out_q.status};

  assert property (@(posedge clk_i) disable iff (!rst_ni) load |=> m_axis_tvalid_o)
    else $error("result beat not presented after last byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without a held result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_valid && !advance) |=> (in_valid && $stable(in_beat)))
    else $error("stalled input beat lost or changed");

endmodule

### design/dra_in_stage.sv
module dra_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  dra_pkg::beat_t s_beat_i,
  input  logic          advance_i,
  output logic          valid_o,
  output dra_pkg::beat_t beat_o
);
  import dra_pkg::*;

  logic  valid_q, valid_d;
  beat_t beat_q, beat_d;

  assign s_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    beat_d  = beat_q;
    if (s_ready_o) begin
      valid_d = s_valid_i;
      beat_d  = s_beat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

### design/dra_parser.sv
module dra_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  dra_pkg::beat_t            beat_i,
  input  logic [dra_pkg::IdW-1:0]   expected_id_i,
  output dra_pkg::result_t          result_o
);
  import dra_pkg::*;

  typedef struct packed {
    logic [3:0]      hpos;
    phase_e          phase;
    logic [15:0]     skip;
    logic [15:0]     qleft;
    logic [15:0]     acount;
    logic [AnsW-1:0] aseen;
    logic [LblW-1:0] labels;
    logic [47:0]     rf;
    logic [3:0]      fbi;
    logic [AddrW-1:0] addr;
    status_e         ferr;
    logic            fixed;
  } pstate_t;

  localparam pstate_t StReset = '0;

  pstate_t st_q, st_d, cons;

  always_comb begin : consume
    logic [ByteW-1:0] b;
    logic [AnsW-1:0]  limit;
    logic [AnsW-1:0]  seen_inc;
    logic [15:0]      rr_len;
    logic             rr_a;
    logic             end_ans;
    b        = beat_i.data;
    cons     = st_q;
    end_ans  = 1'b0;
    limit    = (st_q.acount > 16'(MaxAnswers)) ? AnsW'(MaxAnswers) : st_q.acount[AnsW-1:0];
    seen_inc = st_q.aseen + AnsW'(1);
    rr_len   = {st_q.rf[15:8], b};
    rr_a     = (st_q.rf[47:32] == RrTypeA) && (st_q.rf[31:16] == RrClassIn)
               && (st_q.rf[15:0] == RrLenA);
    if (step_i && !st_q.fixed) begin
      case (st_q.phase)
        PH_HEADER: begin
          case (st_q.hpos)
            4'd0: cons.rf = {32'b0, b, 8'b0};
            4'd1: begin
              cons.rf = {32'b0, st_q.rf[15:8], b};
              if ({st_q.rf[15:8], b} != expected_id_i) cons.ferr = ST_ID;
            end
            4'd2: begin
              if (cons.ferr == ST_OK && (b & QrMask) == '0) cons.ferr = ST_NOT_RESP;
              if (cons.ferr == ST_OK && (b & OpcodeMask) != '0) cons.ferr = ST_OPCODE;
            end
            4'd3: if (cons.ferr == ST_OK && (b & RcodeMask) != '0) cons.ferr = ST_RCODE;
            4'd4: cons.qleft  = {b, 8'b0};
            4'd5: cons.qleft  = {st_q.qleft[15:8], b};
            4'd6: cons.acount = {b, 8'b0};
            4'd7: cons.acount = {st_q.acount[15:8], b};
            default: ;
          endcase
          if (st_q.hpos >= 4'(HdrLast)) begin
            if (cons.ferr == ST_OK && st_q.acount == '0) cons.ferr = ST_NO_ANSWERS;
            if (cons.ferr != ST_OK) begin
              cons.fixed = 1'b1;
            end else begin
              cons.rf     = '0;
              cons.labels = '0;
              cons.skip   = '0;
              cons.phase  = (st_q.qleft != '0) ? PH_QNAME : PH_ANAME;
            end
          end else begin
            cons.hpos = st_q.hpos + 4'd1;
          end
        end
        PH_QNAME, PH_ANAME: begin
          if (st_q.skip != '0) begin
            cons.skip = st_q.skip - 16'd1;
          end else if ((b & PtrMask) == PtrMask) begin
            cons.phase = (st_q.phase == PH_QNAME) ? PH_QPTR : PH_APTR;
          end else if (b == '0) begin
            if (st_q.phase == PH_QNAME) begin
              cons.phase = PH_QTAIL;
              cons.skip  = 16'(QTailLen);
            end else begin
              cons.phase = PH_RRHDR;
              cons.fbi   = '0;
              cons.rf    = '0;
            end
          end else begin
            cons.labels = st_q.labels + LblW'(1);
            if (cons.labels > LblW'(MaxLabels)) begin
              cons.ferr  = (st_q.phase == PH_QNAME) ? ST_QUESTION : ST_ANSWER_NAME;
              cons.fixed = 1'b1;
            end else begin
              cons.skip = {8'b0, b};
            end
          end
        end
        PH_QPTR: begin
          cons.phase = PH_QTAIL;
          cons.skip  = 16'(QTailLen);
        end
        PH_QTAIL: begin
          if (st_q.skip != '0) cons.skip = st_q.skip - 16'd1;
          if (cons.skip == '0) begin
            cons.qleft  = st_q.qleft - 16'd1;
            cons.labels = '0;
            cons.skip   = '0;
            cons.phase  = (cons.qleft != '0) ? PH_QNAME : PH_ANAME;
          end
        end
        PH_APTR: begin
          cons.phase = PH_RRHDR;
          cons.fbi   = '0;
          cons.rf    = '0;
        end
        PH_RRHDR: begin
          case (st_q.fbi)
            4'd0: cons.rf[47:40] = b;
            4'd1: cons.rf[39:32] = b;
            4'd2: cons.rf[31:24] = b;
            4'd3: cons.rf[23:16] = b;
            4'd8: cons.rf[15:8]  = b;
            4'd9: cons.rf[7:0]   = b;
            default: ;
          endcase
          cons.fbi = st_q.fbi + 4'd1;
          if (st_q.fbi >= 4'(RrHdrLast)) begin
            cons.skip = rr_len;
            cons.addr = '0;
            if (rr_len == '0) end_ans = 1'b1;
            else cons.phase = PH_RDATA;
          end
        end
        default: begin
          if (rr_a) cons.addr = {st_q.addr[AddrW-ByteW-1:0], b};
          if (st_q.skip != '0) cons.skip = st_q.skip - 16'd1;
          if (cons.skip == '0) begin
            if (rr_a) begin
              cons.ferr  = ST_OK;
              cons.fixed = 1'b1;
            end else begin
              end_ans = 1'b1;
            end
          end
        end
      endcase
      if (end_ans) begin
        cons.aseen = seen_inc;
        if (seen_inc >= limit) begin
          cons.ferr  = ST_NO_A;
          cons.fixed = 1'b1;
        end else begin
          cons.phase  = PH_ANAME;
          cons.labels = '0;
          cons.skip   = '0;
        end
      end
    end
  end

  always_comb begin : outputs
    result_o.status  = cons.fixed ? cons.ferr : end_error(cons.phase);
    result_o.address = (cons.fixed && cons.ferr == ST_OK) ? cons.addr : '0;
  end

  always_comb begin : next_state
    st_d = (step_i && beat_i.last) ? StReset : cons;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StReset;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dra_pkg::*;

  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainLimit = 20000;
  localparam logic [15:0] RrTypeCname = 16'd5;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [ByteW-1:0]    s_axis_tdata_i = '0;
  logic                s_axis_tlast_i = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [IdW-1:0]      cfg_data_i = '0;

  dns_response_a_record_extractor DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // [7:0] data_byte
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),   // [3:0] status, [35:4] address, rest zero
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  int errors = 0;
  int bytes_sent = 0;
  int msgs_sent = 0;
  int results_checked = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic stall_req = 1'b0;
  int unsigned hold_left = 0;

  result_t lookup_q[$];
  logic [7:0] pkt[$];

  // parser shadow state
  logic [15:0] model_id;
  logic [3:0]  hdr_pos;
  phase_e      phase;
  logic [15:0] skip_left;
  logic [15:0] q_left;
  logic [15:0] an_count;
  logic [6:0]  an_seen;
  logic [7:0]  label_cnt;
  logic [47:0] rr_fields;
  logic [3:0]  rr_idx;
  logic [31:0] addr_acc;
  status_e     verdict;
  logic        settled;

  function automatic void clear_parse();
    hdr_pos = '0;
    phase = PH_HEADER;
    skip_left = '0;
    q_left = '0;
    an_count = '0;
    an_seen = '0;
    label_cnt = '0;
    rr_fields = '0;
    rr_idx = '0;
    addr_acc = '0;
    verdict = ST_OK;
    settled = 1'b0;
  endfunction

  function automatic void settle(input status_e code);
    verdict = code;
    settled = 1'b1;
  endfunction

  function automatic logic record_is_a();
    return rr_fields[47:32] == RrTypeA && rr_fields[31:16] == RrClassIn &&
           rr_fields[15:0] == RrLenA;
  endfunction

  function automatic void start_answer();
    phase = PH_ANAME;
    label_cnt = '0;
    skip_left = '0;
  endfunction

  function automatic void close_answer();
    logic [15:0] cap;
    cap = (an_count > MaxAnswers) ? 16'(MaxAnswers) : an_count;
    an_seen = an_seen + 7'd1;
    if (16'(an_seen) >= cap) settle(ST_NO_A);
    else start_answer();
  endfunction

  function automatic void next_section();
    if (q_left != 0) begin
      phase = PH_QNAME;
      label_cnt = '0;
      skip_left = '0;
    end else begin
      start_answer();
    end
  endfunction

  function automatic logic name_step(input logic [7:0] b, input phase_e ptr_ph,
                                     input status_e err);
    if (skip_left != 0) begin
      skip_left = skip_left - 16'd1;
      return 1'b0;
    end
    if ((b & PtrMask) == PtrMask) begin
      phase = ptr_ph;
      return 1'b0;
    end
    if (b == 8'd0) return 1'b1;
    label_cnt = label_cnt + 8'd1;
    if (label_cnt > MaxLabels) begin
      settle(err);
      return 1'b0;
    end
    skip_left = 16'(b);
    return 1'b0;
  endfunction

  function automatic void header_step(input logic [7:0] b);
    logic [3:0] p;
    p = hdr_pos;
    case (p)
      4'd0: rr_fields = {32'd0, b, 8'd0};
      4'd1: begin
        rr_fields[7:0] = b;
        if (rr_fields[15:0] != model_id) verdict = ST_ID;
      end
      4'd2: begin
        if (verdict == ST_OK && (b & QrMask) == 8'd0) verdict = ST_NOT_RESP;
        if (verdict == ST_OK && (b & OpcodeMask) != 8'd0) verdict = ST_OPCODE;
      end
      4'd3: if (verdict == ST_OK && (b & RcodeMask) != 8'd0) verdict = ST_RCODE;
      4'd4: q_left = {b, 8'd0};
      4'd5: q_left[7:0] = b;
      4'd6: an_count = {b, 8'd0};
      4'd7: an_count[7:0] = b;
      default: ;
    endcase
    if (p >= HdrLast) begin
      if (verdict == ST_OK && an_count == 0) verdict = ST_NO_ANSWERS;
      if (verdict != ST_OK) begin
        settled = 1'b1;
        return;
      end
      rr_fields = '0;
      next_section();
      return;
    end
    hdr_pos = p + 4'd1;
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    logic [3:0] i;
    case (phase)
      PH_HEADER: header_step(b);
      PH_QNAME: begin
        if (name_step(b, PH_QPTR, ST_QUESTION)) begin
          phase = PH_QTAIL;
          skip_left = 16'(QTailLen);
        end
      end
      PH_QPTR: begin
        phase = PH_QTAIL;
        skip_left = 16'(QTailLen);
      end
      PH_QTAIL: begin
        if (skip_left != 0) skip_left = skip_left - 16'd1;
        if (skip_left == 0) begin
          q_left = q_left - 16'd1;
          next_section();
        end
      end
      PH_ANAME, PH_APTR: begin
        logic name_done;
        if (phase == PH_APTR) name_done = 1'b1;
        else name_done = name_step(b, PH_APTR, ST_ANSWER_NAME);
        if (name_done && !settled) begin
          phase = PH_RRHDR;
          rr_idx = '0;
          rr_fields = '0;
        end
      end
      PH_RRHDR: begin
        i = rr_idx;
        case (i)
          4'd0: rr_fields[47:40] = b;
          4'd1: rr_fields[39:32] = b;
          4'd2: rr_fields[31:24] = b;
          4'd3: rr_fields[23:16] = b;
          4'd8: rr_fields[15:8] = b;
          4'd9: rr_fields[7:0] = b;
          default: ;
        endcase
        rr_idx = i + 4'd1;
        if (i >= RrHdrLast) begin
          skip_left = rr_fields[15:0];
          addr_acc = '0;
          if (skip_left == 0) close_answer();
          else phase = PH_RDATA;
        end
      end
      default: begin
        if (record_is_a()) addr_acc = {addr_acc[23:0], b};
        if (skip_left != 0) skip_left = skip_left - 16'd1;
        if (skip_left == 0) begin
          if (record_is_a()) settle(ST_OK);
          else close_answer();
        end
      end
    endcase
  endfunction

  function automatic status_e cutoff_status();
    case (phase)
      PH_HEADER:                   return ST_SHORT;
      PH_QNAME, PH_QPTR, PH_QTAIL: return ST_QUESTION;
      PH_ANAME, PH_APTR:           return ST_ANSWER_NAME;
      PH_RRHDR:                    return ST_RR_HEADER;
      default:                     return ST_RDATA;
    endcase
  endfunction

  function automatic void track_dns_byte(input logic [7:0] b, input logic last);
    result_t r;
    if (!settled) parse_byte(b);
    if (last) begin
      if (!settled) settle(cutoff_status());
      r.status = verdict;
      r.address = (verdict == ST_OK) ? addr_acc : '0;
      lookup_q.push_back(r);
      clear_parse();
    end
  endfunction

  // message assembly
  function automatic void put16(input logic [15:0] v);
    pkt.push_back(v[15:8]);
    pkt.push_back(v[7:0]);
  endfunction

  function automatic void put_random(input int n);
    repeat (n) pkt.push_back(8'($urandom));
  endfunction

  function automatic void put_header(input logic [15:0] id, input logic [7:0] fl,
                                     input logic [7:0] rc, input logic [15:0] qd,
                                     input logic [15:0] an);
    put16(id);
    pkt.push_back(fl);
    pkt.push_back(rc);
    put16(qd);
    put16(an);
    put_random(4);
  endfunction

  function automatic void put_label(input logic [7:0] len);
    pkt.push_back(len);
    put_random(int'(len));
  endfunction

  function automatic void put_flat_labels(input int n);
    repeat (n) begin
      pkt.push_back(8'd1);
      pkt.push_back(8'($urandom));
    end
  endfunction

  function automatic void put_name(input int labels, input bit ptr);
    repeat (labels) put_label(8'($urandom_range(3, 1)));
    if (ptr) begin
      pkt.push_back(PtrMask | 8'($urandom_range(63, 0)));
      pkt.push_back(8'($urandom));
    end else begin
      pkt.push_back(8'd0);
    end
  endfunction

  function automatic void put_question(input int labels, input bit ptr);
    put_name(labels, ptr);
    put_random(4);
  endfunction

  function automatic void put_record(input int labels, input bit ptr,
                                     input logic [15:0] rtype, input logic [15:0] rclass,
                                     input logic [15:0] rlen, input logic [31:0] addr);
    put_name(labels, ptr);
    put16(rtype);
    put16(rclass);
    put_random(4);
    put16(rlen);
    for (int k = 0; k < int'(rlen); k++)
      pkt.push_back(k < 4 ? addr[31-8*k -: 8] : 8'($urandom));
  endfunction

  function automatic void trim_pkt(input int n);
    while (pkt.size() > n) pkt.delete(pkt.size() - 1);
  endfunction

  function automatic void build_random_msg();
    logic [15:0] id, qd, an;
    logic [7:0]  fl, rc;
    int nq, na, pos;
    if ($urandom_range(99, 0) < 8) begin
      put_random($urandom_range(24, 1));
      return;
    end
    id = ($urandom_range(9, 0) == 0) ? 16'($urandom) : model_id;
    fl = 8'h80 | (8'($urandom) & 8'h87);
    if ($urandom_range(9, 0) == 0) fl = 8'($urandom);
    rc = 8'($urandom) & 8'hF0;
    if ($urandom_range(9, 0) == 0) rc = 8'($urandom);
    qd = 16'($urandom_range(2, 0));
    an = 16'($urandom_range(3, 1));
    case ($urandom_range(19, 0))
      0: an = 16'd0;
      1: an = 16'($urandom);
      2: qd = 16'($urandom);
      default: ;
    endcase
    put_header(id, fl, rc, qd, an);
    nq = (qd > 3) ? 3 : int'(qd);
    na = (an > 4) ? 4 : int'(an);
    repeat (nq) put_question($urandom_range(3, 0), 1'($urandom_range(1, 0)));
    repeat (na) begin
      case ($urandom_range(5, 0))
        0, 1: put_record($urandom_range(2, 0), 1'($urandom_range(1, 0)), RrTypeA,
                         RrClassIn, RrLenA, $urandom);
        2: put_record($urandom_range(2, 0), 1'($urandom_range(1, 0)), RrTypeCname,
                      RrClassIn, 16'($urandom_range(8, 0)), $urandom);
        3: put_record($urandom_range(2, 0), 1'($urandom_range(1, 0)), RrTypeA,
                      16'($urandom_range(4, 2)), RrLenA, $urandom);
        4: put_record($urandom_range(2, 0), 1'($urandom_range(1, 0)), RrTypeA,
                      RrClassIn, 16'($urandom_range(6, 0)), $urandom);
        default: put_record($urandom_range(2, 0), 1'($urandom_range(1, 0)),
                            16'($urandom), 16'($urandom), 16'($urandom_range(6, 0)),
                            $urandom);
      endcase
    end
    case ($urandom_range(9, 0))
      0: trim_pkt($urandom_range(pkt.size(), 1));
      1: begin
        pos = $urandom_range(pkt.size() - 1, 0);
        pkt[pos] = 8'($urandom);
      end
      2: put_random($urandom_range(6, 1));
      default: ;
    endcase
  endfunction

  // output side: random stalls, plus one long hold counted here
  always @(posedge clk_i) begin
    if (stall_req) hold_left <= HoldCycles;
    else if (hold_left != 0) hold_left <= hold_left - 1;
    m_axis_tready_i <= !stall_req && hold_left == 0 &&
                       ($urandom_range(99, 0) >= recv_stall_pct);
  end

  result_t    want_r;
  logic [3:0] got_status;
  logic [31:0] got_addr;
  logic [OutPadW-1:0] got_pad;

  // sample at the falling edge: both handshake signals are stable until the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_status = m_axis_tdata_o[StatusW-1:0];
      got_addr = m_axis_tdata_o[StatusW +: AddrW];
      got_pad = m_axis_tdata_o[OutDataW-1 -: OutPadW];
      results_checked++;
      if (lookup_q.size() == 0) begin
        $display("%0t: unexpected result status %0d address %h", $time, got_status, got_addr);
        errors++;
      end else begin
        want_r = lookup_q.pop_front();
        if (got_status != want_r.status) begin
          $display("%0t: status mismatch expected %0d actual %0d", $time,
                   want_r.status, got_status);
          errors++;
        end
        if (got_addr != want_r.address) begin
          $display("%0t: address mismatch expected %h actual %h", $time,
                   want_r.address, got_addr);
          errors++;
        end
        if (got_pad != '0) begin
          $display("%0t: pad bits mismatch expected 0 actual %h", $time, got_pad);
          errors++;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    logic rdy;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= b;
    s_axis_tlast_i <= last;
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready_o;
      @(posedge clk_i);
    end while (!rdy);
    track_dns_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_pkt();
    for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
    pkt.delete();
    msgs_sent++;
  endtask

  task automatic settle_idle();
    int guard;
    guard = 0;
    s_axis_tvalid_i <= 1'b0;
    while (lookup_q.size() != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
    if (lookup_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, lookup_q.size());
      errors++;
      lookup_q.delete();
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_expected_id(input logic [15:0] id);
    logic rdy;
    settle_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= id;
    do begin
      @(negedge clk_i);
      rdy = cfg_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    cfg_valid_i <= 1'b0;
    model_id = id;
  endtask

  task automatic test_header_checks();
    int cuts[7] = '{12, 15, 19, 22, 27, 35, 37};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    pkt.push_back(8'hFF);
    send_pkt();
    put_header(16'hBEEF, 8'h00, 8'h0F, 16'd0, 16'd0);
    trim_pkt(11);
    send_pkt();
    put_header(16'h1234, 8'h00, 8'h00, 16'd0, 16'd1);
    send_pkt();
    put_header(16'h0000, 8'h7F, 8'h00, 16'd0, 16'd1);
    send_pkt();
    put_header(16'h0000, 8'hF8, 8'h00, 16'd0, 16'd1);
    send_pkt();
    put_header(16'h0000, 8'h87, 8'h0F, 16'd0, 16'd1);
    send_pkt();
    put_header(16'h0000, 8'h80, 8'hF0, 16'd0, 16'd0);
    send_pkt();
    put_header(16'h0000, 8'h81, 8'h80, 16'd1, 16'd1);
    put_question(2, 1'b0);
    put_record(1, 1'b0, RrTypeA, RrClassIn, RrLenA, 32'hFFFF_FFFF);
    put_random(5);
    send_pkt();
    put_header(16'h0000, 8'h80, 8'h00, 16'd0, 16'd1);
    put_record(0, 1'b1, RrTypeA, RrClassIn, RrLenA, 32'h0000_0000);
    send_pkt();
    put_header(16'h0000, 8'h80, 8'h00, 16'd0, 16'd4);
    put_record(1, 1'b1, RrTypeCname, RrClassIn, 16'd6, $urandom);
    put_record(0, 1'b1, RrTypeA, 16'd3, RrLenA, $urandom);
    put_record(2, 1'b0, RrTypeA, RrClassIn, 16'd5, $urandom);
    put_record(0, 1'b0, RrTypeA, RrClassIn, RrLenA, 32'hC0A8_0001);
    send_pkt();
    put_header(16'h0000, 8'h80, 8'h00, 16'd2, 16'd2);
    put_question(0, 1'b1);
    put_question(1, 1'b1);
    put_record(0, 1'b1, 16'd28, RrClassIn, 16'd16, $urandom);
    put_record(0, 1'b1, RrTypeA, RrClassIn, 16'd0, 32'd0);
    send_pkt();
    put_header(16'h0000, 8'h80, 8'h00, 16'd1, 16'd1);
    put_label(8'h40);
    put_label(8'h80);
    pkt.push_back(8'd0);
    put_random(4);
    put_record(0, 1'b1, RrTypeA, RrClassIn, RrLenA, $urandom);
    send_pkt();
    // cut a fixed-layout message at points across its sections, and send it once uncut
    foreach (cuts[c]) begin
      put_header(16'h0000, 8'h80, 8'h00, 16'd1, 16'd1);
      put_label(8'd3);
      pkt.push_back(8'd0);
      put_random(4);
      put_record(0, 1'b1, RrTypeA, RrClassIn, RrLenA, $urandom);
      trim_pkt(cuts[c]);
      send_pkt();
    end
    put_header(16'h0000, 8'h80, 8'h00, 16'd0, 16'd1);
    send_pkt();
  endtask

  task automatic test_answer_limit();
    put_header(16'h0000, 8'h80, 8'h00, 16'd0, 16'hFFFF);
    repeat (MaxAnswers) put_record(0, 1'b0, RrTypeCname, RrClassIn, 16'd0, 32'd0);
    put_record(0, 1'b0, RrTypeA, RrClassIn, RrLenA, $urandom);
    send_pkt();
  endtask

  task automatic test_label_guard();
    put_header(16'h0000, 8'h80, 8'h00, 16'd1, 16'd1);
    put_flat_labels(MaxLabels + 1);
    send_pkt();
    put_header(16'h0000, 8'h80, 8'h00, 16'd0, 16'd1);
    put_flat_labels(MaxLabels);
    put_record(0, 1'b0, RrTypeA, RrClassIn, RrLenA, $urandom);
    send_pkt();
  endtask

  task automatic test_id_register();
    write_expected_id(16'hFFFF);
    put_header(16'hFFFF, 8'h80, 8'h00, 16'd0, 16'd1);
    put_record(0, 1'b1, RrTypeA, RrClassIn, RrLenA, $urandom);
    send_pkt();
    put_header(16'hFFFE, 8'h80, 8'h00, 16'd0, 16'd1);
    send_pkt();
    put_header(16'h7FFF, 8'h80, 8'h00, 16'd0, 16'd1);
    send_pkt();
  endtask

  task automatic test_random_traffic(input int n_bytes, input int idle_pct,
                                     input int stall_pct);
    int start;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      build_random_msg();
      send_pkt();
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    s_axis_tvalid_i <= 1'b0;
    stall_req <= 1'b1;
    @(posedge clk_i);
    stall_req <= 1'b0;
    repeat (30) begin
      pkt.push_back(8'($urandom));
      send_pkt();
    end
    repeat (2) begin
      build_random_msg();
      send_pkt();
    end
  endtask

  initial begin
    model_id = '0;
    clear_parse();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_header_checks();
    test_answer_limit();
    test_label_guard();
    test_id_register();
    test_random_traffic(50, 0, 0);
    write_expected_id(16'($urandom));
    test_random_traffic(50, 68, 0);
    write_expected_id(16'h0000);
    test_random_traffic(50, 0, 68);
    write_expected_id(16'($urandom));
    test_random_traffic(50, 26, 26);
    test_output_backpressure();
    settle_idle();
    $display("tb_top: %0d bytes in %0d messages sent, %0d results checked", bytes_sent,
             msgs_sent, results_checked);
    $display("tb_top: header, section, cap and guard cases, four idle mixes, long output hold");
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: timeout with %0d results outstanding", lookup_q.size());
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
